// File: hdl/vtyp_pkg.sv
// ---------------------------------------------------------------------------
// vtyp_pkg
// Shared widths, constants and the CORDIC step-angle table for the
// vector-to-yaw/pitch core.
// ---------------------------------------------------------------------------
`default_nettype none

package vtyp_pkg;

    localparam int COORD_WIDTH   = 24;              // coordinate word, Q16.8
    localparam int DIFF_WIDTH    = COORD_WIDTH + 1; // target minus eye
    localparam int SQ_WIDTH      = 2 * DIFF_WIDTH;  // square / sum of squares
    localparam int RAD_WIDTH     = 64;              // radicand
    localparam int ROOT_WIDTH    = RAD_WIDTH / 2;
    localparam int SQ_UP         = 31 - COORD_WIDTH;
    localparam int YAW_SHIFT     = 55 - COORD_WIDTH;
    localparam int GUARD         = 24;
    localparam int ACC_FRAC      = 20;
    localparam int XY_WIDTH      = 60;              // CORDIC x/y datapath
    localparam int Z_WIDTH       = 32;              // CORDIC angle accumulator
    localparam int TABLE_LEN     = 24;
    localparam int DEF_STEPS     = 16;
    localparam int DEF_FRAC_BITS = 7;
    localparam int YAW_WIDTH     = 16;
    localparam int PITCH_WIDTH   = 15;

    // atan(2^-i) in degrees, ACC_FRAC fraction bits
    function automatic logic signed [Z_WIDTH-1:0] step_angle(input int idx);
        logic signed [Z_WIDTH-1:0] a;
        case (idx)
            0:  a = 32'sd47185920;
            1:  a = 32'sd27855475;
            2:  a = 32'sd14718068;
            3:  a = 32'sd7471121;
            4:  a = 32'sd3750058;
            5:  a = 32'sd1876857;
            6:  a = 32'sd938658;
            7:  a = 32'sd469357;
            8:  a = 32'sd234682;
            9:  a = 32'sd117342;
            10: a = 32'sd58671;
            11: a = 32'sd29335;
            12: a = 32'sd14668;
            13: a = 32'sd7334;
            14: a = 32'sd3667;
            15: a = 32'sd1833;
            16: a = 32'sd917;
            17: a = 32'sd458;
            18: a = 32'sd229;
            19: a = 32'sd115;
            20: a = 32'sd57;
            21: a = 32'sd29;
            22: a = 32'sd14;
            23: a = 32'sd7;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: hdl/vector_to_yaw_pitch_core.sv
// ---------------------------------------------------------------------------
// vector_to_yaw_pitch_core
// Yaw and pitch from a viewer to a target point (head, or body when the
// head x is negative), by a pipelined square root and two CORDIC units.
// ---------------------------------------------------------------------------
// Stages from start to o_strobe:
//   3 front stages, 32 square-root stages, 1 + CORDIC_STEPS CORDIC stages,
//   1 output stage. Throughput: one word per cycle; busy stays low.
// Reset: synchronous active-low i_rst_n clears every valid bit; words in
//   flight are dropped and no strobe follows until new words enter.
// ---------------------------------------------------------------------------
`default_nettype none

module vector_to_yaw_pitch_core
    import vtyp_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = DEF_FRAC_BITS,
    parameter int CORDIC_STEPS    = DEF_STEPS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    output logic                          busy,
    input  wire signed [COORD_WIDTH-1:0]  i_head_x,
    input  wire signed [COORD_WIDTH-1:0]  i_head_y,
    input  wire signed [COORD_WIDTH-1:0]  i_head_z,
    input  wire signed [COORD_WIDTH-1:0]  i_body_x,
    input  wire signed [COORD_WIDTH-1:0]  i_body_y,
    input  wire signed [COORD_WIDTH-1:0]  i_body_z,
    input  wire signed [COORD_WIDTH-1:0]  i_eye_x,
    input  wire signed [COORD_WIDTH-1:0]  i_eye_y,
    input  wire signed [COORD_WIDTH-1:0]  i_eye_z,
    output logic                          o_strobe,
    output logic [YAW_WIDTH-1:0]          o_yaw,
    output logic signed [PITCH_WIDTH-1:0] o_pitch
);

    localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [Z_WIDTH-1:0] RND_HALF = Z_WIDTH'(1) <<< (RND_SH - 1);
    localparam logic signed [Z_WIDTH-1:0] FULL = Z_WIDTH'(360) <<< ANGLE_FRAC_BITS;
    localparam logic signed [Z_WIDTH-1:0] LIM  = Z_WIDTH'(90) <<< ANGLE_FRAC_BITS;
    // sideband through the root: yaw-zero flag, dx, dy, dz
    localparam int SQ_SIDE_W = 1 + 3 * DIFF_WIDTH;

    // never stalls: a word may enter every cycle
    assign busy = 1'b0;

    // ---- stage 1: pick the target point, subtract the eye ----
    logic                         r1_vld;
    logic signed [DIFF_WIDTH-1:0] r1_dx, r1_dy, r1_dz;
    logic                         n_use_head;
    logic signed [COORD_WIDTH-1:0] n_tx, n_ty, n_tz;

    assign n_use_head = !i_head_x[COORD_WIDTH-1];
    assign n_tx = n_use_head ? i_head_x : i_body_x;
    assign n_ty = n_use_head ? i_head_y : i_body_y;
    assign n_tz = n_use_head ? i_head_z : i_body_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start && !busy;
        end
        r1_dx <= DIFF_WIDTH'(n_tx) - DIFF_WIDTH'(i_eye_x);
        r1_dy <= DIFF_WIDTH'(n_ty) - DIFF_WIDTH'(i_eye_y);
        r1_dz <= DIFF_WIDTH'(n_tz) - DIFF_WIDTH'(i_eye_z);
    end

    // ---- stage 2: square the horizontal magnitudes ----
    logic                         r2_vld;
    logic [SQ_WIDTH-1:0]          r2_sqa, r2_sqb;
    logic signed [DIFF_WIDTH-1:0] r2_dx, r2_dy, r2_dz;
    logic [DIFF_WIDTH-1:0]        n_ma, n_mb;

    assign n_ma = r1_dx[DIFF_WIDTH-1] ? DIFF_WIDTH'(-r1_dx) : DIFF_WIDTH'(r1_dx);
    assign n_mb = r1_dy[DIFF_WIDTH-1] ? DIFF_WIDTH'(-r1_dy) : DIFF_WIDTH'(r1_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
        r2_sqa <= SQ_WIDTH'(n_ma) * SQ_WIDTH'(n_ma);
        r2_sqb <= SQ_WIDTH'(n_mb) * SQ_WIDTH'(n_mb);
        r2_dx  <= r1_dx;
        r2_dy  <= r1_dy;
        r2_dz  <= r1_dz;
    end

    // ---- stage 3: sum of squares, scaled up for the root ----
    logic                         r3_vld;
    logic [RAD_WIDTH-1:0]         r3_rad;
    logic [SQ_SIDE_W-1:0]         r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
        r3_rad  <= RAD_WIDTH'(r2_sqa + r2_sqb) << (2 * SQ_UP);
        r3_side <= {(r2_dx == '0) && (r2_dy == '0), r2_dx, r2_dy, r2_dz};
    end

    // ---- horizontal distance ----
    logic                  s_vld;
    logic [ROOT_WIDTH-1:0] s_root;
    logic [SQ_SIDE_W-1:0]  s_side;

    vtyp_isqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r3_vld),
        .i_rad   (r3_rad),
        .i_side  (r3_side),
        .o_vld   (s_vld),
        .o_root  (s_root),
        .o_side  (s_side)
    );

    // ---- unpack and build the CORDIC vectors ----
    logic                         s_yaw_zero;
    logic signed [DIFF_WIDTH-1:0] s_dx, s_dy, s_dz;
    logic signed [XY_WIDTH-1:0]   s_yaw_x, s_yaw_y, s_pit_x, s_pit_y;
    logic                         s_pit_zero;

    assign {s_yaw_zero, s_dx, s_dy, s_dz} = s_side;
    // yaw: x = -dy, y = dx
    assign s_yaw_x = (-XY_WIDTH'(s_dy)) <<< YAW_SHIFT;
    assign s_yaw_y = XY_WIDTH'(s_dx) <<< YAW_SHIFT;
    // pitch: x = horizontal distance, y = dz, both with guard bits
    assign s_pit_x = XY_WIDTH'(s_root) <<< GUARD;
    assign s_pit_y = XY_WIDTH'(s_dz) <<< (SQ_UP + GUARD);
    assign s_pit_zero = (s_root == '0) && (s_dz == '0);

    logic                       c_yaw_vld, c_pit_vld;
    logic signed [Z_WIDTH-1:0]  c_yaw_z, c_pit_z;
    logic                       c_yaw_zero, c_pit_zero;

    vtyp_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (1)
    ) u_cordic_yaw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_vld),
        .i_x     (s_yaw_x),
        .i_y     (s_yaw_y),
        .i_side  (s_yaw_zero),
        .o_vld   (c_yaw_vld),
        .o_z     (c_yaw_z),
        .o_side  (c_yaw_zero)
    );

    vtyp_cordic #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W (1)
    ) u_cordic_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (s_vld),
        .i_x     (s_pit_x),
        .i_y     (s_pit_y),
        .i_side  (s_pit_zero),
        .o_vld   (c_pit_vld),
        .o_z     (c_pit_z),
        .o_side  (c_pit_zero)
    );

    // ---- output stage: round half up, wrap yaw, clamp pitch ----
    logic signed [Z_WIDTH-1:0] n_yaw_r, n_yaw, n_pit_r, n_pit;

    always_comb begin
        n_yaw_r = (c_yaw_z + RND_HALF) >>> RND_SH;
        n_yaw   = n_yaw_r;
        if (n_yaw_r < 0) begin
            n_yaw = n_yaw_r + FULL;
        end
        if (n_yaw >= FULL) begin
            n_yaw = n_yaw - FULL;
        end
        if (c_yaw_zero) begin
            n_yaw = '0;
        end

        n_pit_r = (c_pit_z + RND_HALF) >>> RND_SH;
        n_pit   = n_pit_r;
        if (n_pit_r > LIM) begin
            n_pit = LIM;
        end
        if (n_pit_r < -LIM) begin
            n_pit = -LIM;
        end
        if (c_pit_zero) begin
            n_pit = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= c_yaw_vld && c_pit_vld;
        end
        o_yaw   <= n_yaw[YAW_WIDTH-1:0];
        o_pitch <= n_pit[PITCH_WIDTH-1:0];
    end

endmodule

`default_nettype wire

// File: hdl/vtyp_isqrt.sv
// ---------------------------------------------------------------------------
// vtyp_isqrt
// Pipelined integer square root, one result bit per stage, with a sideband
// word carried alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module vtyp_isqrt
    import vtyp_pkg::*;
#(
    parameter int SIDE_W = 1
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_vld,
    input  wire [RAD_WIDTH-1:0]    i_rad,
    input  wire [SIDE_W-1:0]       i_side,
    output logic                   o_vld,
    output logic [ROOT_WIDTH-1:0]  o_root,
    output logic [SIDE_W-1:0]      o_side
);

    logic                 r_vld  [0:ROOT_WIDTH];
    logic [RAD_WIDTH-1:0] r_rem  [0:ROOT_WIDTH];
    logic [RAD_WIDTH-1:0] r_res  [0:ROOT_WIDTH];
    logic [SIDE_W-1:0]    r_side [0:ROOT_WIDTH];

    assign r_vld[0]  = i_vld;
    assign r_rem[0]  = i_rad;
    assign r_res[0]  = '0;
    assign r_side[0] = i_side;

    for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
        localparam logic [RAD_WIDTH-1:0] BIT = RAD_WIDTH'(1) << (RAD_WIDTH - 2 - 2 * k);
        logic [RAD_WIDTH-1:0] n_trial;
        logic [RAD_WIDTH-1:0] n_rem;
        logic [RAD_WIDTH-1:0] n_res;

        always_comb begin
            n_trial = r_res[k] + BIT;
            if (r_rem[k] >= n_trial) begin
                n_rem = r_rem[k] - n_trial;
                n_res = (r_res[k] >> 1) + BIT;
            end else begin
                n_rem = r_rem[k];
                n_res = r_res[k] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1]  <= n_rem;
            r_res[k+1]  <= n_res;
            r_side[k+1] <= r_side[k];
        end
    end

    assign o_vld  = r_vld[ROOT_WIDTH];
    assign o_root = r_res[ROOT_WIDTH][ROOT_WIDTH-1:0];
    assign o_side = r_side[ROOT_WIDTH];

endmodule

`default_nettype wire

// File: hdl/vtyp_cordic.sv
// ---------------------------------------------------------------------------
// vtyp_cordic
// Unrolled vectoring CORDIC: a half-turn pre-rotation stage, then one
// registered micro-rotation per step. Gives the angle of (x, y) in degrees.
// ---------------------------------------------------------------------------
`default_nettype none

module vtyp_cordic
    import vtyp_pkg::*;
#(
    parameter int STEPS  = DEF_STEPS,
    parameter int SIDE_W = 1
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_vld,
    input  wire signed [XY_WIDTH-1:0]  i_x,
    input  wire signed [XY_WIDTH-1:0]  i_y,
    input  wire [SIDE_W-1:0]           i_side,
    output logic                       o_vld,
    output logic signed [Z_WIDTH-1:0]  o_z,
    output logic [SIDE_W-1:0]          o_side
);

    localparam logic signed [Z_WIDTH-1:0] HALF_TURN = Z_WIDTH'(180) <<< ACC_FRAC;

    logic                       r_vld  [0:STEPS];
    logic signed [XY_WIDTH-1:0] r_x    [0:STEPS];
    logic signed [XY_WIDTH-1:0] r_y    [0:STEPS];
    logic signed [Z_WIDTH-1:0]  r_z    [0:STEPS];
    logic [SIDE_W-1:0]          r_side [0:STEPS];

    // turn a vector in the left half-plane by half a turn
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_vld;
        end
        if (i_x[XY_WIDTH-1]) begin
            r_x[0] <= -i_x;
            r_y[0] <= -i_y;
            r_z[0] <= i_y[XY_WIDTH-1] ? -HALF_TURN : HALF_TURN;
        end else begin
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_z[0] <= '0;
        end
        r_side[0] <= i_side;
    end

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic signed [Z_WIDTH-1:0] ANG = step_angle(i);
        logic signed [XY_WIDTH-1:0] n_xs;
        logic signed [XY_WIDTH-1:0] n_ys;

        assign n_xs = r_x[i] >>> i;
        assign n_ys = r_y[i] >>> i;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i+1] <= 1'b0;
            end else begin
                r_vld[i+1] <= r_vld[i];
            end
            if (!r_y[i][XY_WIDTH-1]) begin
                r_x[i+1] <= r_x[i] + n_ys;
                r_y[i+1] <= r_y[i] - n_xs;
                r_z[i+1] <= r_z[i] + ANG;
            end else begin
                r_x[i+1] <= r_x[i] - n_ys;
                r_y[i+1] <= r_y[i] + n_xs;
                r_z[i+1] <= r_z[i] - ANG;
            end
            r_side[i+1] <= r_side[i];
        end
    end

    assign o_vld  = r_vld[STEPS];
    assign o_z    = r_z[STEPS];
    assign o_side = r_side[STEPS];

endmodule

`default_nettype wire

// File: tb/tb_vector_to_yaw_pitch_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_vector_to_yaw_pitch_core
// Self-checking bench for the yaw/pitch core. A directed table covers the
// zero vector, head/body selection, coordinate extremes, vertical aims and
// wrap/clamp corners. Random words follow, with bursts of idle cycles. Each
// strobed result is checked against a bit-exact CORDIC angle predictor.
// ---------------------------------------------------------------------------

module tb_vector_to_yaw_pitch_core;
    import vtyp_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int N_RANDOM    = 1100;
    localparam int CALM_TAIL   = 150;     // final random words sent back to back
    localparam int DRAIN_WAIT  = 80;      // cycles after the last result
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_STEPS     = DEF_STEPS;
    localparam int N_FRAC      = DEF_FRAC_BITS;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    typedef struct {
        t_coord hx, hy, hz, bx, by, bz, ex, ey, ez;
    } t_aim_word;

    typedef struct {
        logic [YAW_WIDTH-1:0]          yaw;
        logic signed [PITCH_WIDTH-1:0] pitch;
    } t_aim_angles;

    typedef struct {
        t_aim_word   w;
        bit          known;   // expected value typed in below
        t_aim_angles ang;
    } t_aim_row;

    localparam t_coord CMAX = 24'sh7FFFFF;
    localparam t_coord CMIN = 24'sh800000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_coord hx = '0, hy = '0, hz = '0, bx = '0, by = '0, bz = '0;
    t_coord ex = '0, ey = '0, ez = '0;
    logic   o_strobe;
    logic [YAW_WIDTH-1:0]          o_yaw;
    logic signed [PITCH_WIDTH-1:0] o_pitch;

    t_aim_angles pending_angles[$];
    int          n_fail = 0;
    int          n_words = 0;
    int          n_checked = 0;
    int          n_cycles = 0;

    // atan(2^-i) in degrees, 20 fraction bits
    longint atan_deg_q20[24] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
        234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29, 14, 7
    };

    vector_to_yaw_pitch_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_head_x(hx), .i_head_y(hy), .i_head_z(hz),
        .i_body_x(bx), .i_body_y(by), .i_body_z(bz),
        .i_eye_x (ex), .i_eye_y (ey), .i_eye_z (ez),
        .o_strobe(o_strobe),
        .o_yaw   (o_yaw),
        .o_pitch (o_pitch)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Vectoring CORDIC: angle of (x, y) in degrees, 20 fraction bits.
    // Arithmetic shift of a signed longint rounds toward minus infinity.
    function automatic longint vector_deg(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        if (x < 0) begin
            z = (y >= 0) ? (longint'(180) <<< ACC_FRAC) : -(longint'(180) <<< ACC_FRAC);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < N_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_deg_q20[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_deg_q20[i];
            end
        end
        return z;
    endfunction

    function automatic longint round_deg(longint z);
        return (z + (longint'(1) <<< (ACC_FRAC - N_FRAC - 1))) >>> (ACC_FRAC - N_FRAC);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic t_aim_angles predict_aim(t_aim_word w);
        t_aim_angles a;
        longint dx, dy, dz, yaw, pitch, r, zs;
        longint unsigned ax, ay, sum;
        longint full, lim;
        bit head;
        full = 360 <<< N_FRAC;
        lim  = 90 <<< N_FRAC;
        head = (w.hx >= 0);
        dx = longint'(head ? w.hx : w.bx) - longint'(w.ex);
        dy = longint'(head ? w.hy : w.by) - longint'(w.ey);
        dz = longint'(head ? w.hz : w.bz) - longint'(w.ez);
        yaw = 0;
        pitch = 0;
        if (dx != 0 || dy != 0) begin
            yaw = round_deg(vector_deg(-dy <<< YAW_SHIFT, dx <<< YAW_SHIFT));
            if (yaw < 0) yaw = yaw + full;
            if (yaw >= full) yaw = yaw - full;
        end
        ax  = (dx < 0) ? -dx : dx;
        ay  = (dy < 0) ? -dy : dy;
        sum = (ax * ax + ay * ay) << (2 * SQ_UP);
        r   = longint'(int_sqrt(sum));
        zs  = dz <<< SQ_UP;
        if (r != 0 || zs != 0) begin
            pitch = round_deg(vector_deg(r <<< GUARD, zs <<< GUARD));
            if (pitch > lim) pitch = lim;
            if (pitch < -lim) pitch = -lim;
        end
        a.yaw   = yaw[YAW_WIDTH-1:0];
        a.pitch = pitch[PITCH_WIDTH-1:0];
        return a;
    endfunction

    function automatic t_aim_word mk(t_coord hx_, t_coord hy_, t_coord hz_,
                                     t_coord bx_, t_coord by_, t_coord bz_,
                                     t_coord ex_, t_coord ey_, t_coord ez_);
        t_aim_word w;
        w.hx = hx_; w.hy = hy_; w.hz = hz_;
        w.bx = bx_; w.by = by_; w.bz = bz_;
        w.ex = ex_; w.ey = ey_; w.ez = ez_;
        return w;
    endfunction

    // Monitor: check the strobed result first, then record any accepted word.
    always @(posedge i_clk) begin
        t_aim_angles exp_a;
        n_cycles <= n_cycles + 1;
        if (i_rst_n && o_strobe) begin
            if (pending_angles.size() == 0) begin
                $error("result with nothing outstanding: yaw %0d pitch %0d", o_yaw, o_pitch);
                n_fail++;
            end else begin
                exp_a = pending_angles.pop_front();
                n_checked++;
                if (o_yaw !== exp_a.yaw) begin
                    $error("yaw expected %0d actual %0d", exp_a.yaw, o_yaw);
                    n_fail++;
                end
                if (o_pitch !== exp_a.pitch) begin
                    $error("pitch expected %0d actual %0d", exp_a.pitch, o_pitch);
                    n_fail++;
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            pending_angles.push_back(predict_aim(mk(hx, hy, hz, bx, by, bz, ex, ey, ez)));
            n_words++;
        end
    end

    // Watchdog: end the run if it hangs.
    always @(posedge i_clk) begin
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Present one word and hold it until the core takes it.
    task automatic send_word(t_aim_word w);
        start <= 1'b1;
        hx <= w.hx; hy <= w.hy; hz <= w.hz;
        bx <= w.bx; by <= w.by; bz <= w.bz;
        ex <= w.ex; ey <= w.ey; ez <= w.ez;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic idle_burst(bit allow);
        int n;
        if (allow && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic t_coord rnd_coord();
        return t_coord'($urandom);
    endfunction

    // Mostly short vectors near the eye, so every octant and small-angle
    // corner is reached; some fully random words toggle every bit.
    function automatic t_aim_word rnd_word();
        t_aim_word w;
        int span;
        w = mk(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
               rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
        if ($urandom_range(0, 3) != 0) begin
            span = (1 << $urandom_range(0, 20));
            w.ex = t_coord'($signed($urandom_range(0, 2 * 4000000)) - 4000000);
            w.ey = t_coord'($signed($urandom_range(0, 2 * 4000000)) - 4000000);
            w.ez = t_coord'($signed($urandom_range(0, 2 * 4000000)) - 4000000);
            w.hx = w.ex + t_coord'($signed($urandom_range(0, 2 * span)) - span);
            w.hy = w.ey + t_coord'($signed($urandom_range(0, 2 * span)) - span);
            w.hz = w.ez + t_coord'($signed($urandom_range(0, 2 * span)) - span);
            w.bx = w.ex + t_coord'($signed($urandom_range(0, 2 * span)) - span);
            w.by = w.ey + t_coord'($signed($urandom_range(0, 2 * span)) - span);
            w.bz = w.ez + t_coord'($signed($urandom_range(0, 2 * span)) - span);
            if ($urandom_range(0, 7) == 0) w.hy = w.ey;   // dy zero
            if ($urandom_range(0, 7) == 0) w.hz = w.ez;   // dz zero
        end
        return w;
    endfunction

    t_aim_row    directed[$];
    t_aim_angles zero_ang;

    initial begin
        zero_ang.yaw   = '0;
        zero_ang.pitch = '0;
        // Zero vector: both angles are zero.
        directed.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, zero_ang});
        directed.push_back('{mk(100, 200, 300, 0, 0, 0, 100, 200, 300), 1'b1, zero_ang});
        // Head x negative picks the body point, zero vector there.
        directed.push_back('{mk(-1, 5, 5, 7, 8, 9, 7, 8, 9), 1'b1, zero_ang});
        directed.push_back('{mk(CMIN, CMAX, CMIN, 0, 0, 0, 0, 0, 0), 1'b0, zero_ang});
        // Straight up and down: no horizontal distance.
        directed.push_back('{mk(0, 0, 256, 0, 0, 0, 0, 0, 0), 1'b0, zero_ang});
        directed.push_back('{mk(0, 0, -1, 0, 0, 0, 0, 0, 0), 1'b0, zero_ang});
        directed.push_back('{mk(0, 0, CMAX, 0, 0, 0, 0, 0, CMIN), 1'b0, zero_ang});
        directed.push_back('{mk(0, 0, CMIN, 0, 0, 0, 0, 0, CMAX), 1'b0, zero_ang});
        // Cardinal headings.
        directed.push_back('{mk(0, -256, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_ang});
        directed.push_back('{mk(256, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_ang});
        directed.push_back('{mk(0, 256, 0, 0, 0, 0, 0, 0, 0), 1'b0, zero_ang});
        directed.push_back('{mk(0, 0, 0, 0, 0, 0, 256, 0, 0), 1'b0, zero_ang});
        // Yaw just under 360 wraps to zero after rounding.
        directed.push_back('{mk(0, -CMAX, 0, 0, 0, 0, 1, 0, 0), 1'b0, zero_ang});
        directed.push_back('{mk(0, 0, 0, 0, 0, 0, 1, CMAX, 0), 1'b0, zero_ang});
        // Pitch near the vertical, clamp corner.
        directed.push_back('{mk(1, 0, CMAX, 0, 0, 0, 0, 0, CMIN), 1'b0, zero_ang});
        directed.push_back('{mk(1, 0, CMIN, 0, 0, 0, 0, 0, CMAX), 1'b0, zero_ang});
        // Coordinate extremes, largest differences.
        directed.push_back('{mk(CMAX, CMAX, CMAX, 0, 0, 0, CMIN, CMIN, CMIN), 1'b0, zero_ang});
        directed.push_back('{mk(0, CMIN, CMIN, 0, 0, 0, CMAX, CMAX, CMAX), 1'b0, zero_ang});
        directed.push_back('{mk(-1, 0, 0, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX), 1'b0, zero_ang});
        directed.push_back('{mk(CMIN, 0, 0, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN), 1'b0, zero_ang});
        directed.push_back('{mk(1, 1, 1, 0, 0, 0, 0, 0, 0), 1'b0, zero_ang});
        directed.push_back('{mk(-1, 0, 0, -1, -1, -1, 0, 0, 0), 1'b0, zero_ang});

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            // Typed-in rows must agree with the predictor as well.
            if (directed[k].known) begin
                t_aim_angles p;
                p = predict_aim(directed[k].w);
                if (p.yaw !== directed[k].ang.yaw || p.pitch !== directed[k].ang.pitch) begin
                    $error("table row %0d: yaw expected %0d actual %0d, pitch expected %0d actual %0d",
                           k, directed[k].ang.yaw, p.yaw, directed[k].ang.pitch, p.pitch);
                    n_fail++;
                end
            end
            send_word(directed[k].w);
            idle_burst(1'b1);
        end

        for (int k = 0; k < N_RANDOM; k++) begin
            send_word(rnd_word());
            idle_burst(k < N_RANDOM - CALM_TAIL);
        end
        start <= 1'b0;

        // Drain: wait for every outstanding result, then a little longer.
        while (pending_angles.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("sent %0d words (directed table plus random), checked %0d results",
                 n_words, n_checked);
        $display("covered head/body selection, extremes, vertical aims, wrap and clamp");
        if (n_fail == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/vtyp_pkg.sv
hdl/vtyp_isqrt.sv
hdl/vtyp_cordic.sv
hdl/vector_to_yaw_pitch_core.sv
tb/tb_vector_to_yaw_pitch_core.sv
